[design/assert_macros.svh]
// Assertion macros used by the RTL file of the escape decoder.
// Needs a clock named clk and a reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[design/cesd_pkg.sv]
// Types, character codes and helpers for the C escape sequence decoder.
// No dependencies; used by c_escape_sequence_decoder_unit.
`default_nettype none

package cesd_pkg;

  // Saturation limit of the running output byte count.
  localparam int MAX_OUT = 4096;
  localparam int OCNT_W  = $clog2(MAX_OUT + 1);

  // Result slots produced by one character, at most.
  localparam int SLOTS = 3;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2,
    MODE_OCTAL  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_EMIT    = 2'd0,
    ACT_RETRACT = 2'd1,
    ACT_TERM    = 2'd2
  } action_t;

  // Source characters with a meaning of their own.
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [4:0] OCT_HI   = 5'b00110;  // upper bits of '0'..'7'
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  // Events that one character raises, in the order they are reported.
  typedef struct packed {
    logic       num_emit;   // close an open number, emit its value
    logic       chr_emit;   // emit chr_byte
    logic [7:0] chr_byte;
    logic       retract;    // retract previous byte
    logic       flush;      // number still open at end of string
    logic       term;       // terminator
  } ev_t;

  // Hex digit decode: bit 4 is the valid flag, bits 3:0 the value.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/c_escape_sequence_decoder_unit.sv]
// C escape sequence decoder: one source character in, up to three results out.
// Depends on cesd_pkg and assert_macros.svh.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   input   | in_valid, in_stall, in_char, last_char   | in
//   output  | out_valid, out_stall, action, out_byte,  | out
//           | last_of_run                              |
//
// Flow: a character is held in the input register, then is decoded in one
// pass into a three-slot result buffer. One character per cycle is sustained
// while each gives at most one result and out_stall is low; a character with
// more results holds the buffer until each has gone, one transfer per cycle.
// Reset (rst, synchronous) empties both registers and returns the decoder to
// normal mode with a zero number and a zero count.
// Stalls: out_stall holds the buffer; the input register still takes one
// character, and in_stall rises only while that character cannot advance.
`default_nettype none

`include "assert_macros.svh"

module c_escape_sequence_decoder_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       last_char,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      action,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);

  // Input register.
  logic       in_full;
  logic [7:0] ir_char;
  logic       ir_last;

  // Decoder state.
  cesd_pkg::mode_t           mode, mode_next;
  logic [7:0]                numv, numv_next;
  logic [cesd_pkg::OCNT_W-1:0] ocnt, ocnt_next;

  // Result buffer: filled in one pass, drained from slot 0 upward.
  cesd_pkg::action_t slot_act  [cesd_pkg::SLOTS];
  logic [7:0]        slot_byte [cesd_pkg::SLOTS];
  logic [1:0]        cnt;
  logic [1:0]        rd_idx;

  // Combinational decode results.
  cesd_pkg::ev_t     ev;
  logic [7:0]        numv_upd;   // number after this character, before end clear
  cesd_pkg::action_t new_act  [cesd_pkg::SLOTS];
  logic [7:0]        new_byte [cesd_pkg::SLOTS];
  logic [1:0]        new_cnt;

  logic in_xfer;
  logic out_xfer;
  logic last_slot;
  logic advance;

  assign out_valid = (cnt != 2'd0);
  assign out_xfer  = out_valid && !out_stall;
  assign last_slot = (rd_idx == cnt - 2'd1);

  // Advance the held character once the buffer is empty or frees this cycle.
  assign advance  = in_full && ((cnt == 2'd0) || (out_xfer && last_slot));
  assign in_stall = in_full && !advance;
  assign in_xfer  = in_valid && !in_stall;

  // Next decoder mode and number, plus the events this character raises.
  always_comb begin
    cesd_pkg::mode_t m;
    logic [7:0]      nv;
    logic [4:0]      hv;
    m  = mode;
    nv = numv;
    hv = cesd_pkg::hex_val(ir_char);
    ev = '0;
    ev.chr_byte = ir_char;
    unique case (mode)
      cesd_pkg::MODE_NORMAL: begin
        if (ir_char == cesd_pkg::CH_BSL) begin
          m = cesd_pkg::MODE_ESCAPE;
        end else begin
          ev.chr_emit = 1'b1;
        end
      end
      cesd_pkg::MODE_ESCAPE: begin
        m = cesd_pkg::MODE_NORMAL;
        unique case (ir_char)
          cesd_pkg::CH_DQ, cesd_pkg::CH_BSL: begin
            ev.chr_emit = 1'b1;
          end
          cesd_pkg::CH_N: begin
            ev.chr_emit = 1'b1;
            ev.chr_byte = cesd_pkg::BYTE_LF;
          end
          cesd_pkg::CH_T: begin
            ev.chr_emit = 1'b1;
            ev.chr_byte = cesd_pkg::BYTE_TAB;
          end
          cesd_pkg::CH_R: begin
          end
          cesd_pkg::CH_B: begin
            ev.retract = (ocnt != '0);
          end
          cesd_pkg::CH_X: begin
            m  = cesd_pkg::MODE_HEX;
            nv = 8'd0;
          end
          default: begin
            if (ir_char[7:3] == cesd_pkg::OCT_HI) begin
              m  = cesd_pkg::MODE_OCTAL;
              nv = {5'd0, ir_char[2:0]};
            end else begin
              ev.chr_emit = 1'b1;  // unknown escape keeps the character
            end
          end
        endcase
      end
      cesd_pkg::MODE_HEX, cesd_pkg::MODE_OCTAL: begin
        if (mode == cesd_pkg::MODE_HEX && hv[4]) begin
          nv = {numv[3:0], hv[3:0]};
        end else if (mode == cesd_pkg::MODE_OCTAL && ir_char[7:3] == cesd_pkg::OCT_HI) begin
          nv = {numv[4:0], ir_char[2:0]};
        end else begin
          // Close the number, then treat the character as in normal mode.
          ev.num_emit = 1'b1;
          m = cesd_pkg::MODE_NORMAL;
          if (ir_char == cesd_pkg::CH_BSL) begin
            m = cesd_pkg::MODE_ESCAPE;
          end else begin
            ev.chr_emit = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    ev.flush = ir_last && (m == cesd_pkg::MODE_HEX || m == cesd_pkg::MODE_OCTAL);
    ev.term  = ir_last;
    numv_upd  = nv;
    mode_next = ir_last ? cesd_pkg::MODE_NORMAL : m;
    numv_next = ir_last ? 8'd0 : nv;
  end

  // Pack the events into result slots in report order.
  always_comb begin
    logic [1:0] k;
    k = 2'd0;
    for (int i = 0; i < cesd_pkg::SLOTS; i++) begin
      new_act[i]  = cesd_pkg::ACT_EMIT;
      new_byte[i] = 8'd0;
    end
    if (ev.num_emit) begin
      new_act[k]  = cesd_pkg::ACT_EMIT;
      new_byte[k] = numv;
      k = k + 2'd1;
    end
    if (ev.chr_emit) begin
      new_act[k]  = cesd_pkg::ACT_EMIT;
      new_byte[k] = ev.chr_byte;
      k = k + 2'd1;
    end
    if (ev.retract) begin
      new_act[k]  = cesd_pkg::ACT_RETRACT;
      new_byte[k] = 8'd0;
      k = k + 2'd1;
    end
    // The flushed value is the number after this character, before reset.
    if (ev.flush) begin
      new_act[k]  = cesd_pkg::ACT_EMIT;
      new_byte[k] = numv_upd;
      k = k + 2'd1;
    end
    if (ev.term) begin
      new_act[k]  = cesd_pkg::ACT_TERM;
      new_byte[k] = 8'd0;
      k = k + 2'd1;
    end
    new_cnt = k;
  end

  // Running byte count: saturate on emit, drop on retract, clear at the end.
  always_comb begin
    ocnt_next = ocnt;
    for (int i = 0; i < cesd_pkg::SLOTS; i++) begin
      if (2'(i) < new_cnt) begin
        if (new_act[i] == cesd_pkg::ACT_EMIT) begin
          if (ocnt_next < cesd_pkg::OCNT_W'(cesd_pkg::MAX_OUT)) begin
            ocnt_next = ocnt_next + 1'b1;
          end
        end else if (new_act[i] == cesd_pkg::ACT_RETRACT) begin
          ocnt_next = ocnt_next - 1'b1;
        end
      end
    end
    if (ir_last) begin
      ocnt_next = '0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_xfer) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ir_char <= in_char;
      ir_last <= last_char;
    end
  end

  // Decoder state advances with the held character.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cesd_pkg::MODE_NORMAL;
      numv <= 8'd0;
      ocnt <= '0;
    end else if (advance) begin
      mode <= mode_next;
      numv <= numv_next;
      ocnt <= ocnt_next;
    end
  end

  // Result buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      rd_idx <= 2'd0;
    end else if (advance) begin
      cnt    <= new_cnt;
      rd_idx <= 2'd0;
    end else if (out_xfer) begin
      if (last_slot) begin
        cnt    <= 2'd0;
        rd_idx <= 2'd0;
      end else begin
        rd_idx <= rd_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < cesd_pkg::SLOTS; i++) begin
        slot_act[i]  <= new_act[i];
        slot_byte[i] <= new_byte[i];
      end
    end
  end

  // Present the slot under the read index.
  always_comb begin
    unique case (rd_idx)
      2'd1: begin
        action   = slot_act[1];
        out_byte = slot_byte[1];
      end
      2'd2: begin
        action   = slot_act[2];
        out_byte = slot_byte[2];
      end
      default: begin
        action   = slot_act[0];
        out_byte = slot_byte[0];
      end
    endcase
    last_of_run = last_slot;
  end

  `ASSERT_CLK(a_rd_in_range, out_valid |-> (rd_idx < cnt), "read index beyond filled slots")
  `ASSERT_CLK(a_term_last, (out_valid && action == cesd_pkg::ACT_TERM) |-> last_of_run,
              "terminator not last result of its character")
  `ASSERT_CLK(a_zero_byte, (out_valid && action != cesd_pkg::ACT_EMIT) |-> (out_byte == 8'd0),
              "nonzero byte on retract or terminator")
  `ASSERT_NEVER(a_stall_empty, in_stall && !in_full, "input stalled with empty register")

endmodule

`default_nettype wire

[tb/tb_c_escape_sequence_decoder_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for c_escape_sequence_decoder_unit: random and directed strings,
// checked transfer by transfer against an in-bench decoder. Depends on cesd_pkg and the unit.

module tb_c_escape_sequence_decoder_unit;
  import cesd_pkg::*;

  localparam int LONG_HOLD = 80;   // cycles of the forced receiver hold-off
  localparam int TAIL_WAIT = 20;   // settle time once nothing is expected

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } src_char_t;

  typedef struct packed {
    action_t    act;
    logic [7:0] data;
    logic       fin;
  } dec_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char = 8'h00;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] action;
  logic [7:0] out_byte;
  logic       last_of_run;

  c_escape_sequence_decoder_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char     (in_char),
    .last_char   (last_char),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .action      (action),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Characters waiting to be offered, and decoded results waiting to arrive.
  src_char_t   char_q[$];
  dec_result_t decoded_q[$];
  dec_result_t run_q[$];      // results of the character being decoded

  // Decoder state kept by the bench.
  mode_t             dec_mode = MODE_NORMAL;
  logic [7:0]        num_acc = 8'h00;
  logic [OCNT_W-1:0] byte_count = '0;

  int err_count = 0;
  int items_added = 0;
  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  int hold_req = 0;           // bump to force one long receiver hold-off
  int hold_seen = 0;
  int gap_left = 0;
  int stall_left = 0;

  // Mostly no idling, often a short gap, now and then a long one.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %02h, want %02h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------
  function automatic int hex_weight(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic bit is_octal(logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  // The running count stops at MAX_OUT; emitted bytes beyond it still go out.
  function automatic void put_byte(logic [7:0] b);
    run_q.push_back('{ACT_EMIT, b, 1'b0});
    if (byte_count < MAX_OUT) byte_count++;
  endfunction

  function automatic void take_plain(logic [7:0] c);
    if (c == CH_BSL) dec_mode = MODE_ESCAPE;
    else put_byte(c);
  endfunction

  function automatic void take_escape(logic [7:0] c);
    dec_mode = MODE_NORMAL;
    case (c)
      CH_DQ:  put_byte(CH_DQ);
      CH_N:   put_byte(BYTE_LF);
      CH_T:   put_byte(BYTE_TAB);
      CH_BSL: put_byte(CH_BSL);
      CH_R:   ;
      CH_B: begin
        // Retract only when something is left to take back.
        if (byte_count > 0) begin
          run_q.push_back('{ACT_RETRACT, 8'h00, 1'b0});
          byte_count--;
        end
      end
      CH_X: begin
        dec_mode = MODE_HEX;
        num_acc = 8'h00;
      end
      default: begin
        if (is_octal(c)) begin
          dec_mode = MODE_OCTAL;
          num_acc = {5'd0, c[2:0]};
        end else begin
          put_byte(c);   // unknown escape: drop the backslash, keep the char
        end
      end
    endcase
  endfunction

  // Decode one accepted character and queue the results it causes.
  function automatic void decode_char(logic [7:0] c, logic lst);
    int d;
    run_q.delete();
    case (dec_mode)
      MODE_NORMAL: take_plain(c);
      MODE_ESCAPE: take_escape(c);
      MODE_HEX: begin
        d = hex_weight(c);
        if (d >= 0) begin
          num_acc = {num_acc[3:0], d[3:0]};
        end else begin
          dec_mode = MODE_NORMAL;
          put_byte(num_acc);
          take_plain(c);
        end
      end
      default: begin
        if (is_octal(c)) begin
          num_acc = {num_acc[4:0], c[2:0]};
        end else begin
          dec_mode = MODE_NORMAL;
          put_byte(num_acc);
          take_plain(c);
        end
      end
    endcase
    if (lst) begin
      // Flush an open number, terminate, and start the next string clean.
      if (dec_mode == MODE_HEX || dec_mode == MODE_OCTAL) put_byte(num_acc);
      run_q.push_back('{ACT_TERM, 8'h00, 1'b0});
      dec_mode = MODE_NORMAL;
      num_acc = 8'h00;
      byte_count = '0;
    end
    if (run_q.size() > 0) run_q[$].fin = 1'b1;
    foreach (run_q[i]) decoded_q.push_back(run_q[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Source side: offer queued characters with random gaps. A stalled
  // character stays on the port unchanged until its transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : source
    src_char_t nxt;
    if (rst) begin
      in_valid  <= 1'b0;
      in_char   <= 8'h00;
      last_char <= 1'b0;
      gap_left  <= 0;
    end else begin
      if (in_valid && !in_stall) decode_char(in_char, last_char);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (char_q.size() > 0) begin
          nxt = char_q.pop_front();
          in_valid  <= 1'b1;
          in_char   <= nxt.ch;
          last_char <= nxt.lst;
          gap_left  <= src_idle_on ? pick_idle() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random holds, plus a long forced hold on request so the
  // block fills up and pushes back on its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sink_stall
    int n;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_seen  <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen  <= hold_req;
      stall_left <= LONG_HOLD - 1;
      out_stall  <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      n = sink_idle_on ? pick_idle() : 0;
      if (n > 0) begin
        stall_left <= n - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every output transfer against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sink_check
    dec_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        flag_mismatch("transfer with nothing expected, action", {6'd0, action}, 8'h00);
      end else begin
        want = decoded_q.pop_front();
        if (action !== want.act)
          flag_mismatch("action", {6'd0, action}, {6'd0, want.act});
        if (out_byte !== want.data)
          flag_mismatch("out_byte", out_byte, want.data);
        if (last_of_run !== want.fin)
          flag_mismatch("last_of_run", {7'd0, last_of_run}, {7'd0, want.fin});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_char(logic [7:0] c, logic lst);
    char_q.push_back('{c, lst});
    items_added++;
  endtask

  task automatic add_esc(logic [7:0] c, logic lst);
    add_char(CH_BSL, 1'b0);
    add_char(c, lst);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_BSL);
    return c;
  endfunction

  // One well-formed string with random content; a little noise mixed in.
  task automatic add_random_string();
    logic [7:0] txt[$];
    logic [7:0] simple[6];
    string      hexdig;
    int         kind;
    hexdig = "0123456789abcdefABCDEF";
    simple = '{CH_DQ, CH_N, CH_T, CH_BSL, CH_R, CH_B};
    repeat ($urandom_range(1, 10)) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        txt.push_back(plain_byte());
      end else if (kind < 55) begin
        txt.push_back(CH_BSL);
        txt.push_back(simple[$urandom_range(0, 5)]);
      end else if (kind < 65) begin
        txt.push_back(CH_BSL);
        if ($urandom_range(0, 2) == 0) txt.push_back(8'("8" + $urandom_range(0, 1)));
        else txt.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 80) begin
        txt.push_back(CH_BSL);
        txt.push_back(CH_X);
        repeat ($urandom_range(0, 4)) txt.push_back(hexdig[$urandom_range(0, 21)]);
      end else if (kind < 93) begin
        txt.push_back(CH_BSL);
        repeat ($urandom_range(1, 4)) txt.push_back(8'("0" + $urandom_range(0, 7)));
      end else begin
        txt.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 7) == 0) txt.push_back(CH_BSL);   // trailing backslash
    // A stray end mark inside the string now and then breaks it in two.
    foreach (txt[i])
      add_char(txt[i], (i == txt.size() - 1) || ($urandom_range(0, 39) == 0));
  endtask

  // Wait for the source to go quiet and every expected result to arrive.
  task automatic drain();
    while (char_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_strings(int count);
    int start;
    start = items_added;
    while (items_added - start < count) add_random_string();
  endtask

  initial begin : main
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: every escape, retract on empty output, unknown escapes
    // including digit nine, then the terminator.
    add_esc(CH_B, 1'b0);
    add_esc(CH_DQ, 1'b0);
    add_esc(CH_N, 1'b0);
    add_esc(CH_T, 1'b0);
    add_esc(CH_BSL, 1'b0);
    add_esc(CH_R, 1'b0);
    add_esc(CH_B, 1'b0);
    add_esc("q", 1'b0);
    add_esc("9", 1'b1);
    // Hex with both letter cases, closed by a backslash that opens an octal,
    // closed in turn by a backslash; then hex with no digits at the end.
    add_esc(CH_X, 1'b0);
    add_char("F", 1'b0);
    add_char("f", 1'b0);
    add_char(CH_BSL, 1'b0);
    add_char("7", 1'b0);
    add_char("7", 1'b0);
    add_esc(CH_X, 1'b1);
    // Hex with no digits before a zero byte, top byte, trailing backslash.
    add_esc(CH_X, 1'b0);
    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b0);
    add_char(CH_BSL, 1'b1);
    // Octal still open at the end of the string.
    add_esc("3", 1'b0);
    add_char("7", 1'b1);
    drain();

    // Random strings with idling on both sides; force a long receiver
    // hold-off while the source keeps offering.
    random_strings(75);
    hold_req++;
    drain();

    // Back-to-back stretch with no idling at all.
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    random_strings(40);
    drain();

    // A final short random burst with idling back on.
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    random_strings(15);
    drain();

    repeat (TAIL_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
